>>> rtl/ttc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package ttc_pkg;

  // Cell store geometry
  localparam int CELL_COUNT = 4096;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  // Wide enough for row*columns+column and for a scan index plus one row
  localparam int IDX_W      = 14;
  localparam int COLS_MAX   = 128;

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_SET_POS = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [1:0] CFG_LAST_ROW   = 2'd1;
  localparam logic [1:0] CFG_COLUMNS    = 2'd2;

  // Register reset values
  localparam logic [7:0] TEXT_COLOR_RST = 8'd7;
  localparam logic [4:0] LAST_ROW_RST   = 5'd24;
  localparam logic [7:0] COLUMNS_RST    = 8'd80;

  // Control bytes
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  typedef logic [15:0] cell_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [7:0]  target_row;
    logic [7:0]  target_col;
    logic [11:0] read_address;
  } ttc_in_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [7:0]  cursor_col;
    logic [15:0] cell_data;
    logic        scrolled;
  } ttc_out_t;

  // Write port of the cell store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    cell_t             data;
  } ttc_wr_t;

  // True when a cell index lies inside the store
  function automatic logic in_store(logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(CELL_COUNT);
  endfunction

endpackage

>>> rtl/ttc_cell_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_cell_store
// Character cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ttc_cell_store (
  input  logic                       clk,
  input  ttc_pkg::ttc_wr_t           wr,
  input  logic [ttc_pkg::ADDR_W-1:0] raddr,
  output ttc_pkg::cell_t             rdata
);

  ttc_pkg::cell_t mem [ttc_pkg::CELL_COUNT];
  ttc_pkg::cell_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/text_console_cell_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// Teletype text console: cursor, cell store, scroll and clear sequencer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_data   (ttc_pkg::ttc_in_t)
// out      output     out_valid / out_ready    out_data  (ttc_pkg::ttc_out_t)
// cfg      input      cfg_we                   cfg_index, cfg_wdata
//
// After reset a clearing pass writes zero to all CELL_COUNT cells, one a cycle; in_ready
// stays low until it ends. One item at a time: a stored character passes S_EXEC, S_CHAR,
// S_DONE before the next accept, a position S_EXEC, S_DONE, a read S_EXEC, S_READ, S_DONE. A
// scroll copies each cell by a store read, then a write, and blanks the bottom row at one cell
// a cycle; clear blanks (last_row+1)*columns cells at one a cycle. One multiply-add unit forms
// cell indexes and screen sizes. A stalled result holds the sequencer in S_DONE until out_ready.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttc_pkg::ttc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ttc_pkg::ttc_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_wdata
);

  localparam int IW = ttc_pkg::IDX_W;
  localparam int AW = ttc_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_EXEC, S_CHAR, S_READ, S_TOTAL,
    S_SCR_RD, S_SCR_WR, S_FILL, S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  ttc_pkg::ttc_in_t  item_r, item_nxt;
  logic [4:0]        row_r, row_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [IW-1:0]     total_r, total_nxt;
  logic              clear_r, clear_nxt;
  logic              scr_r, scr_nxt;
  logic              src_ok_r, src_ok_nxt;
  ttc_pkg::cell_t    cell_r, cell_nxt;
  logic [AW-1:0]     init_addr_r, init_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  ttc_pkg::ttc_out_t out_data_r, out_data_nxt;

  logic [7:0]        text_color_r;
  logic [4:0]        last_row_r;
  logic [7:0]        columns_r;

  logic [7:0]        cols_eff;
  ttc_pkg::cell_t    blank;
  logic [5:0]        mul_a;
  logic [7:0]        mul_b;
  logic [7:0]        mul_c;
  logic [IW-1:0]     mul_res;
  logic [5:0]        adv_row;
  logic              adv_scroll;
  logic [7:0]        col_inc;
  logic              col_wrap;
  logic [IW-1:0]     src_idx;
  logic [7:0]        clamp_col;
  logic [7:0]        clamp_row;

  ttc_pkg::ttc_wr_t  wr;
  logic [AW-1:0]     raddr;
  ttc_pkg::cell_t    rdata;

  ttc_cell_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Columns register: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (columns_r == 8'd0) begin
      cols_eff = 8'd1;
    end else if (columns_r > 8'(ttc_pkg::COLS_MAX)) begin
      cols_eff = 8'(ttc_pkg::COLS_MAX);
    end else begin
      cols_eff = columns_r;
    end
  end

  assign blank = {text_color_r, ttc_pkg::BYTE_SPACE};

  // Shared multiply-add: cell index in S_EXEC, screen size otherwise
  always_comb begin
    mul_b = cols_eff;
    if (state_r == S_EXEC) begin
      mul_a = {1'b0, row_r};
      mul_c = col_r;
    end else begin
      mul_a = {1'b0, last_row_r} + 6'd1;
      mul_c = 8'd0;
    end
  end
  assign mul_res = IW'(mul_a) * IW'(mul_b) + IW'(mul_c);

  assign adv_row    = {1'b0, row_r} + 6'd1;
  assign adv_scroll = adv_row > {1'b0, last_row_r};
  assign col_inc    = col_r + 8'd1;
  assign col_wrap   = col_inc >= cols_eff;
  assign src_idx    = i_r + IW'(cols_eff);
  assign clamp_row  = (item_r.target_row <= {3'd0, last_row_r}) ? item_r.target_row
                                                                : {3'd0, last_row_r};
  assign clamp_col  = (item_r.target_col <= cols_eff) ? item_r.target_col : cols_eff;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    i_nxt         = i_r;
    total_nxt     = total_r;
    clear_nxt     = clear_r;
    scr_nxt       = scr_r;
    src_ok_nxt    = src_ok_r;
    cell_nxt      = cell_r;
    init_addr_nxt = init_addr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr            = '0;
    raddr         = AW'(src_idx);

    unique case (state_r)
      S_INIT: begin
        wr.en   = 1'b1;
        wr.addr = init_addr_r;
        wr.data = '0;
        if (init_addr_r == AW'(ttc_pkg::CELL_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          init_addr_nxt = init_addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          cell_nxt  = '0;
          scr_nxt   = 1'b0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (item_r.op)
          ttc_pkg::OP_WRITE: begin
            priority if (item_r.data_byte == ttc_pkg::BYTE_CR) begin
              col_nxt   = 8'd0;
              state_nxt = S_DONE;
            end else if (item_r.data_byte == ttc_pkg::BYTE_LF) begin
              if (adv_scroll) begin
                clear_nxt = 1'b0;
                state_nxt = S_TOTAL;
              end else begin
                row_nxt   = adv_row[4:0];
                state_nxt = S_DONE;
              end
            end else if (item_r.data_byte == ttc_pkg::BYTE_TAB) begin
              state_nxt = S_DONE;
              if (col_wrap) begin
                col_nxt = 8'd0;
                if (adv_scroll) begin
                  clear_nxt = 1'b0;
                  state_nxt = S_TOTAL;
                end else begin
                  row_nxt = adv_row[4:0];
                end
              end else begin
                col_nxt = col_inc;
              end
            end else begin
              idx_nxt   = mul_res;
              state_nxt = S_CHAR;
            end
          end
          ttc_pkg::OP_SET_POS: begin
            row_nxt   = clamp_row[4:0];
            col_nxt   = clamp_col;
            state_nxt = S_DONE;
          end
          ttc_pkg::OP_CLEAR: begin
            clear_nxt = 1'b1;
            state_nxt = S_TOTAL;
          end
          ttc_pkg::OP_READ: begin
            raddr      = AW'(item_r.read_address);
            src_ok_nxt = ttc_pkg::in_store(IW'(item_r.read_address));
            state_nxt  = S_READ;
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_CHAR: begin
        wr.en     = ttc_pkg::in_store(idx_r);
        wr.addr   = AW'(idx_r);
        wr.data   = {text_color_r, item_r.data_byte};
        state_nxt = S_DONE;
        if (col_wrap) begin
          col_nxt = 8'd0;
          if (adv_scroll) begin
            clear_nxt = 1'b0;
            state_nxt = S_TOTAL;
          end else begin
            row_nxt = adv_row[4:0];
          end
        end else begin
          col_nxt = col_inc;
        end
      end

      S_READ: begin
        cell_nxt  = src_ok_r ? rdata : '0;
        state_nxt = S_DONE;
      end

      S_TOTAL: begin
        total_nxt = mul_res;
        i_nxt     = '0;
        state_nxt = clear_r ? S_FILL : S_SCR_RD;
      end

      // Copy phase: fetch the cell one row below
      S_SCR_RD: begin
        if (src_idx < total_r) begin
          src_ok_nxt = ttc_pkg::in_store(src_idx);
          state_nxt  = S_SCR_WR;
        end else begin
          state_nxt = S_FILL;
        end
      end

      S_SCR_WR: begin
        wr.en     = ttc_pkg::in_store(i_r);
        wr.addr   = AW'(i_r);
        wr.data   = src_ok_r ? rdata : '0;
        i_nxt     = i_r + IW'(1);
        state_nxt = S_SCR_RD;
      end

      // Blank the vacated row, or the whole screen on clear
      S_FILL: begin
        if (i_r < total_r) begin
          wr.en   = ttc_pkg::in_store(i_r);
          wr.addr = AW'(i_r);
          wr.data = blank;
          i_nxt   = i_r + IW'(1);
        end else begin
          if (clear_r) begin
            row_nxt = 5'd0;
            col_nxt = 8'd0;
          end else begin
            row_nxt = last_row_r;
            scr_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.cursor_row = row_r;
          out_data_nxt.cursor_col = col_r;
          out_data_nxt.cell_data  = cell_r;
          out_data_nxt.scrolled   = scr_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_addr_r  <= '0;
      row_r        <= '0;
      col_r        <= '0;
      clear_r      <= 1'b0;
      scr_r        <= 1'b0;
      src_ok_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      text_color_r <= ttc_pkg::TEXT_COLOR_RST;
      last_row_r   <= ttc_pkg::LAST_ROW_RST;
      columns_r    <= ttc_pkg::COLUMNS_RST;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      clear_r     <= clear_nxt;
      scr_r       <= scr_nxt;
      src_ok_r    <= src_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ttc_pkg::CFG_TEXT_COLOR: text_color_r <= cfg_wdata;
          ttc_pkg::CFG_LAST_ROW:   last_row_r   <= cfg_wdata[4:0];
          ttc_pkg::CFG_COLUMNS:    columns_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    i_r        <= i_nxt;
    total_r    <= total_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> tb/tb_text_console_cell_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer_core
// Self-checking bench for the text console cell writer.
// Console operations go in through the valid/ready input. A behavioural
// screen model predicts the cursor, the cell reads and the scroll flag of
// every item. Each result is checked in order. The run covers control bytes,
// cursor clamping, line wrap, scrolling at small and full screen sizes,
// clear, cells outside the store, odd column settings, random idling on both
// sides and long output backpressure.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer_core;
  import ttc_pkg::*;

  // Timeout guard: LIMIT_CYCLES lies far above the slowest correct run
  localparam int         LIMIT_CYCLES = 2_000_000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         MAX_PRINTS   = 30;
  localparam logic [1:0] CFG_SPARE    = 2'd3;  // no register behind this index

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  ttc_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  ttc_out_t   out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  // Screen model state
  cell_t      screen_cells [CELL_COUNT];
  logic [4:0] cur_row;
  logic [7:0] cur_col;
  logic [7:0] color_reg;
  logic [4:0] last_row_reg;
  logic [7:0] columns_reg;
  ttc_out_t   expected_results [$];

  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int scrolls_seen    = 0;
  int reads_seen      = 0;
  int settings_used   = 0;
  int cycle_count     = 0;
  bit idle_on         = 1'b1;
  bit hold_request    = 1'b0;

  text_console_cell_writer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Screen model
  // --------------------------------------------------------------------------
  function automatic int usable_columns();
    if (columns_reg == 0) return 1;
    if (columns_reg > COLS_MAX) return COLS_MAX;
    return int'(columns_reg);
  endfunction

  function automatic cell_t blank_word();
    return {color_reg, BYTE_SPACE};
  endfunction

  function automatic void store_cell(int idx, cell_t v);
    if (idx < CELL_COUNT) screen_cells[idx] = v;
  endfunction

  function automatic cell_t fetch_cell(int idx);
    return (idx < CELL_COUNT) ? screen_cells[idx] : cell_t'(0);
  endfunction

  function automatic void scroll_screen();
    int cols;
    int total;
    cols  = usable_columns();
    total = (int'(last_row_reg) + 1) * cols;
    for (int i = 0; i < total - cols; i++) store_cell(i, fetch_cell(i + cols));
    for (int i = total - cols; i < total; i++) store_cell(i, blank_word());
  endfunction

  // Move down one row, scrolling when the cursor passes the bottom row
  function automatic bit advance_line();
    if (int'(cur_row) + 1 > int'(last_row_reg)) begin
      scroll_screen();
      cur_row = last_row_reg;
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic bit emit_byte(logic [7:0] b);
    int cols;
    cols = usable_columns();
    if (b == BYTE_CR) begin
      cur_col = '0;
      return 1'b0;
    end
    if (b == BYTE_LF) return advance_line();
    if (b != BYTE_TAB) begin
      store_cell(int'(cur_row) * cols + int'(cur_col), {color_reg, b});
    end
    if (int'(cur_col) + 1 >= cols) begin
      cur_col = '0;
      return advance_line();
    end
    cur_col = cur_col + 1'b1;
    return 1'b0;
  endfunction

  function automatic ttc_out_t console_apply(ttc_in_t item);
    ttc_out_t r;
    int       cols;
    r    = '0;
    cols = usable_columns();
    case (item.op)
      OP_WRITE: begin
        r.scrolled = emit_byte(item.data_byte);
      end
      OP_SET_POS: begin
        cur_row = (item.target_row <= last_row_reg) ? item.target_row[4:0] : last_row_reg;
        cur_col = (int'(item.target_col) <= cols) ? item.target_col : 8'(cols);
      end
      OP_CLEAR: begin
        for (int i = 0; i < (int'(last_row_reg) + 1) * cols; i++) store_cell(i, blank_word());
        cur_row = '0;
        cur_col = '0;
      end
      OP_READ: begin
        r.cell_data = fetch_cell(int'(item.read_address));
      end
    endcase
    r.cursor_row = cur_row;
    r.cursor_col = cur_col;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Unused fields carry random bits
  function automatic ttc_in_t make_item(logic [1:0] op);
    ttc_in_t it;
    {it.data_byte, it.target_row, it.target_col} = 24'($urandom);
    it.read_address = 12'($urandom);
    it.op = op;
    return it;
  endfunction

  function automatic ttc_in_t random_item();
    ttc_in_t it;
    int      roll;
    int      span;
    span = (int'(last_row_reg) + 1) * usable_columns();
    roll = $urandom_range(0, 99);
    if (roll < 58) begin
      it   = make_item(OP_WRITE);
      roll = $urandom_range(0, 99);
      if (roll < 70) it.data_byte = 8'($urandom_range(8'h21, 8'h7e));
      else if (roll < 80) it.data_byte = BYTE_CR;
      else if (roll < 90) it.data_byte = BYTE_LF;
      else if (roll < 95) it.data_byte = BYTE_TAB;
    end else if (roll < 70) begin
      it = make_item(OP_SET_POS);
      if ($urandom_range(0, 1) == 1) begin
        it.target_row = 8'($urandom_range(0, last_row_reg));
        it.target_col = 8'($urandom_range(0, usable_columns()));
      end
    end else if (roll < 73) begin
      it = make_item(OP_CLEAR);
    end else begin
      it = make_item(OP_READ);
      // bias reads onto the visible screen
      if ($urandom_range(0, 9) < 7) it.read_address = 12'($urandom_range(0, span - 1));
    end
    return it;
  endfunction

  // Starts at a falling edge, returns at the accepting rising edge with valid still high
  task automatic send_item(input ttc_in_t item);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    expected_results.push_back(console_apply(item));
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    ttc_in_t it;
    it = make_item(OP_WRITE);
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_pos(input logic [7:0] r, input logic [7:0] c);
    ttc_in_t it;
    it = make_item(OP_SET_POS);
    it.target_row = r;
    it.target_col = c;
    send_item(it);
  endtask

  task automatic send_read(input int addr);
    ttc_in_t it;
    it = make_item(OP_READ);
    it.read_address = 12'(addr);
    send_item(it);
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEXT_COLOR: color_reg    = value;
      CFG_LAST_ROW:   last_row_reg = value[4:0];
      CFG_COLUMNS:    columns_reg  = value;
      default: ;
    endcase
  endtask

  task automatic set_screen(input logic [7:0] color, input logic [4:0] bottom,
                            input logic [7:0] cols);
    wait_drained();
    write_reg(CFG_TEXT_COLOR, color);
    write_reg(CFG_LAST_ROW, {3'b000, bottom});
    write_reg(CFG_COLUMNS, cols);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < MAX_PRINTS) begin
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
    errors++;
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // long hold-off, counted here so the sender keeps offering meanwhile
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    ttc_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_data, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", out_data.cursor_row, want.cursor_row);
        if (out_data.cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", out_data.cursor_col, want.cursor_col);
        if (out_data.cell_data !== want.cell_data)
          report_mismatch("cell_data", out_data.cell_data, want.cell_data);
        if (out_data.scrolled !== want.scrolled)
          report_mismatch("scrolled", out_data.scrolled, want.scrolled);
        results_checked++;
        if (want.scrolled) scrolls_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset screen geometry: control bytes, byte extremes, clamping, right edge
  task automatic test_default_screen();
    send_read(0);
    send_read(CELL_COUNT - 1);
    send_byte(8'h41);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(BYTE_TAB);
    send_byte(BYTE_CR);
    send_byte(BYTE_LF);
    send_read(0);
    send_read(2);
    send_pos(8'hff, 8'hff);
    // column at the right edge: stored past the row, then wrap and scroll
    send_byte(8'h5a);
    send_read(24 * 80 + 80);
    send_item(make_item(OP_CLEAR));
    send_read(0);
  endtask

  task automatic test_config_edges();
    // zero columns behaves as one; every printable byte scrolls a one-cell screen
    set_screen(8'hff, 5'd0, 8'd0);
    write_reg(CFG_SPARE, 8'h55);
    send_byte(8'h41);
    send_read(0);
    send_pos(8'd5, 8'd5);
    send_byte(8'h42);
    send_read(1);
    send_byte(BYTE_LF);
    // columns above the maximum on the tallest screen; last cell falls off the store
    set_screen(8'h00, 5'd31, 8'd200);
    send_pos(8'd31, 8'd200);
    send_byte(8'h7e);
    send_read(CELL_COUNT - 1);
    // cursor left below a lowered bottom row
    send_pos(8'd20, 8'd3);
    send_byte(8'h43);
    set_screen(8'h1e, 5'd4, 8'd10);
    send_byte(BYTE_LF);
    send_read(20 * 128 + 3);
  endtask

  task automatic test_backpressure();
    set_screen(8'($urandom), 5'd3, 8'd8);
    idle_on = 1'b0;
    @(posedge clk);
    hold_request = 1'b1;
    repeat (10) send_item(random_item());
    // pause until everything has come back, then carry on
    wait_drained();
    idle_on = 1'b1;
    repeat (6) send_item(random_item());
  endtask

  task automatic test_random_screens();
    int n;
    for (int p = 0; p < 10; p++) begin
      n = 52;
      case (p)
        3: begin
          set_screen(8'($urandom), 5'd31, 8'd128);
          n = 30;
        end
        6: set_screen(8'($urandom), 5'($urandom_range(0, 3)), 8'($urandom_range(129, 255)));
        8: set_screen(8'($urandom), 5'($urandom_range(0, 2)), 8'd0);
        default: set_screen(8'($urandom), 5'($urandom_range(0, 7)), 8'($urandom_range(1, 16)));
      endcase
      // some phases run with no idling on either side
      idle_on = (p % 4 != 1);
      repeat (n) begin
        send_item(random_item());
        if (expected_results[$].cell_data != 0 || in_data.op == OP_READ) reads_seen++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = '0;
    cur_row      = '0;
    cur_col      = '0;
    color_reg    = TEXT_COLOR_RST;
    last_row_reg = LAST_ROW_RST;
    columns_reg  = COLUMNS_RST;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_default_screen();
    test_config_edges();
    test_backpressure();
    test_random_screens();

    wait_drained();
    // let any stray result show up
    repeat (50) @(posedge clk);

    $display("covered %0d items over %0d screen settings, %0d results checked",
             items_sent, settings_used, results_checked);
    $display("random reads %0d, scrolls %0d, mismatches %0d",
             reads_seen, scrolls_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
